// File: rtl/b3d_pkg.sv
`timescale 1ns / 1ps
package b3d_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumRounds = 7;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned DigestWords = 8;
	localparam logic [7:0] FlagsMid = 8'h01;
	localparam logic [7:0] FlagsLast = 8'h0B;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [7:0] cv_t;
	typedef word_t [15:0] msg_t;

	localparam cv_t Iv = '{
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load_byte;
		logic       start_mid;
		logic       start_last;
		logic       step;
		logic       finish;
		logic       emit_clear;
	} cmd_t;

	typedef struct packed {
		logic       full;
		logic       nonempty;
		logic       round_done;
	} stat_t;

	function automatic word_t ror(input word_t w, input int unsigned n);
		ror = (w >> n) | (w << (WordW - n));
	endfunction

	function automatic logic [3:0] perm(input logic [3:0] i);
		logic [3:0] r;
		case (i)
			4'd0: r = 4'd2;
			4'd1: r = 4'd6;
			4'd2: r = 4'd3;
			4'd3: r = 4'd10;
			4'd4: r = 4'd7;
			4'd5: r = 4'd0;
			4'd6: r = 4'd4;
			4'd7: r = 4'd13;
			4'd8: r = 4'd1;
			4'd9: r = 4'd11;
			4'd10: r = 4'd12;
			4'd11: r = 4'd5;
			4'd12: r = 4'd9;
			4'd13: r = 4'd14;
			4'd14: r = 4'd15;
			default: r = 4'd8;
		endcase
		perm = r;
	endfunction

endpackage

// File: rtl/b3d_ctrl.sv
`timescale 1ns / 1ps
module b3d_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           byte_valid,
	input  logic           last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     idx,
	output b3d_pkg::cmd_t  cmd,
	input  b3d_pkg::stat_t st
);

	b3d_pkg::state_t state_q, state_d;
	logic pend_last_q, pend_last_d;
	logic [2:0] idx_q, idx_d;
	logic acc;
	logic cmd_last_q;
	logic load_after_q;

	assign acc = in_valid && in_ready;
	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b3d_pkg::ST_IDLE;
			pend_last_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			pend_last_q <= pend_last_d;
			idx_q <= idx_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pend_last_d = pend_last_q;
		idx_d = idx_q;
		case (state_q)
			b3d_pkg::ST_IDLE: begin
				if (acc) begin
					pend_last_d = last;
					if (byte_valid && st.full) begin
						state_d = b3d_pkg::ST_COMP;
					end else if (last && (st.nonempty || byte_valid)) begin
						state_d = b3d_pkg::ST_WAIT;
					end else if (last) begin
						state_d = b3d_pkg::ST_EMIT;
						idx_d = '0;
					end
				end
			end
			b3d_pkg::ST_COMP: begin
				if (st.round_done) begin
					if (pend_last_q) begin
						state_d = b3d_pkg::ST_WAIT;
						pend_last_d = 1'b0;
					end else begin
						state_d = b3d_pkg::ST_IDLE;
					end
				end
			end
			b3d_pkg::ST_WAIT: begin
				state_d = b3d_pkg::ST_COMP;
				pend_last_d = 1'b0;
			end
			b3d_pkg::ST_EMIT: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_d = b3d_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = b3d_pkg::ST_IDLE;
		endcase
		if (state_q == b3d_pkg::ST_COMP && st.round_done && !pend_last_q && cmd_last_q) begin
			state_d = b3d_pkg::ST_EMIT;
			idx_d = '0;
		end
	end

	// remember whether the running compression is the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_last_q <= 1'b0;
		end else if (cmd.start_last) begin
			cmd_last_q <= 1'b1;
		end else if (cmd.start_mid) begin
			cmd_last_q <= 1'b0;
		end
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == b3d_pkg::ST_IDLE);
		out_valid = (state_q == b3d_pkg::ST_EMIT);
		case (state_q)
			b3d_pkg::ST_IDLE: begin
				cmd.start_mid = acc && byte_valid && st.full;
				cmd.load_byte = acc && byte_valid && !st.full;
			end
			b3d_pkg::ST_COMP: begin
				cmd.step = 1'b1;
				cmd.finish = st.round_done;
				cmd.load_byte = st.round_done && load_after_q;
			end
			b3d_pkg::ST_WAIT: begin
				cmd.start_last = 1'b1;
			end
			b3d_pkg::ST_EMIT: begin
				cmd.emit_clear = out_ready && (idx_q == 3'd7);
			end
			default: cmd = '0;
		endcase
	end

	// byte that triggered a held-block compression lands once it finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_after_q <= 1'b0;
		end else if (cmd.start_mid) begin
			load_after_q <= 1'b1;
		end else if (cmd.finish) begin
			load_after_q <= 1'b0;
		end
	end

endmodule

// File: rtl/b3d_datapath.sv
`timescale 1ns / 1ps
module b3d_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  b3d_pkg::cmd_t  cmd,
	input  logic [2:0]     idx,
	output b3d_pkg::stat_t st,
	output logic [31:0]    digest_word
);

	b3d_pkg::msg_t blk_q;
	logic [6:0] fill_q;
	logic [7:0] pend_byte_q;
	logic [63:0] ctr_q;
	b3d_pkg::cv_t cv_q;
	b3d_pkg::word_t v_q [16];
	b3d_pkg::msg_t m_q;
	logic [3:0] round_q;
	logic [6:0] blen;
	logic active_q;

	b3d_pkg::word_t vn [16];
	b3d_pkg::msg_t mn;

	assign st.full = (fill_q == 7'd64);
	assign st.nonempty = (fill_q != 7'd0);
	assign st.round_done = active_q && (round_q == 4'(2 * b3d_pkg::NumRounds - 1));
	assign digest_word = cv_q[idx];

	function automatic void g(inout b3d_pkg::word_t a, inout b3d_pkg::word_t b,
		inout b3d_pkg::word_t c, inout b3d_pkg::word_t d,
		input b3d_pkg::word_t x, input b3d_pkg::word_t y);
		a = a + b + x;
		d = b3d_pkg::ror(d ^ a, 16);
		c = c + d;
		b = b3d_pkg::ror(b ^ c, 12);
		a = a + b + y;
		d = b3d_pkg::ror(d ^ a, 8);
		c = c + d;
		b = b3d_pkg::ror(b ^ c, 7);
	endfunction

	// one half round per cycle: columns, then diagonals and permute
	always_comb begin
		for (int i = 0; i < 16; i++) vn[i] = v_q[i];
		mn = m_q;
		if (!round_q[0]) begin
			g(vn[0], vn[4], vn[8], vn[12], m_q[0], m_q[1]);
			g(vn[1], vn[5], vn[9], vn[13], m_q[2], m_q[3]);
			g(vn[2], vn[6], vn[10], vn[14], m_q[4], m_q[5]);
			g(vn[3], vn[7], vn[11], vn[15], m_q[6], m_q[7]);
		end else begin
			g(vn[0], vn[5], vn[10], vn[15], m_q[8], m_q[9]);
			g(vn[1], vn[6], vn[11], vn[12], m_q[10], m_q[11]);
			g(vn[2], vn[7], vn[8], vn[13], m_q[12], m_q[13]);
			g(vn[3], vn[4], vn[9], vn[14], m_q[14], m_q[15]);
			for (int i = 0; i < 16; i++) mn[i] = m_q[b3d_pkg::perm(4'(i))];
		end
	end

	assign blen = cmd.start_last ? fill_q : 7'd64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= '0;
			fill_q <= '0;
			pend_byte_q <= '0;
			ctr_q <= '0;
			cv_q <= b3d_pkg::Iv;
			m_q <= '0;
			for (int i = 0; i < 16; i++) v_q[i] <= '0;
			round_q <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.start_mid || cmd.start_last) begin
				m_q <= blk_q;
				for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
				for (int i = 0; i < 4; i++) v_q[i+8] <= b3d_pkg::Iv[i];
				v_q[12] <= b3d_pkg::Iv[4] ^ ctr_q[31:0];
				v_q[13] <= b3d_pkg::Iv[5] ^ ctr_q[63:32];
				v_q[14] <= b3d_pkg::Iv[6] ^ {25'd0, blen};
				v_q[15] <= b3d_pkg::Iv[7] ^ {24'd0,
					(cmd.start_last ? b3d_pkg::FlagsLast : b3d_pkg::FlagsMid)};
				round_q <= '0;
				active_q <= 1'b1;
				if (cmd.start_mid) pend_byte_q <= data_byte;
			end else if (cmd.step) begin
				for (int i = 0; i < 16; i++) v_q[i] <= vn[i];
				m_q <= mn;
				round_q <= round_q + 4'd1;
			end
			if (cmd.finish) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ vn[i] ^ vn[i+8];
				ctr_q <= ctr_q + 64'd1;
				active_q <= 1'b0;
				blk_q <= cmd.load_byte ? b3d_pkg::msg_t'({504'd0, pend_byte_q}) : '0;
				fill_q <= cmd.load_byte ? 7'd1 : 7'd0;
			end else if (cmd.load_byte) begin
				blk_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= data_byte;
				fill_q <= fill_q + 7'd1;
			end
			if (cmd.emit_clear) begin
				cv_q <= b3d_pkg::Iv;
				ctr_q <= '0;
			end
		end
	end

endmodule

// File: rtl/blake3_style_digest_256.sv
`timescale 1ns / 1ps
// BLAKE3-style 256-bit digest over a byte stream.
// Input channel: in_valid/in_ready with data_byte, byte_valid, last. A word
// with byte_valid low and last low is ignored; last high ends the message.
// Output channel: out_valid/out_ready with digest_word, word_index, last_word;
// eight words follow each message end, last_word on word 7.
// Bytes are taken one per cycle while a block fills. A byte arriving on a
// full held block starts a compression (one half round per cycle on one
// shared half-round unit of four G functions), during which in_ready is
// low; the byte lands at its end. At message end with bytes held, a setup
// state (ST_WAIT) and a final compression run before word 0 is offered
// (an empty message offers it the next cycle). in_ready stays low until
// word 7 is taken; a stalled receiver holds each word. After word 7 the
// IV is reloaded and the block counter cleared. Reset (arst_n low) loads
// the IV and clears the buffer, fill count and block counter.
module blake3_style_digest_256 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	b3d_pkg::cmd_t cmd;
	b3d_pkg::stat_t st;
	logic [2:0] idx;

	b3d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .byte_valid(byte_valid),
		.last(last), .in_ready(in_ready), .out_valid(out_valid),
		.out_ready(out_ready), .idx(idx), .cmd(cmd), .st(st)
	);

	b3d_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte), .cmd(cmd),
		.idx(idx), .st(st), .digest_word(digest_word)
	);

	assign word_index = idx;
	assign last_word = (idx == 3'd7);

endmodule
